// ===== sv/tmhq_pkg.sv =====
// ----------------------------------------------------------------------------
// tmhq_pkg
// Shared types and codes of the ternary min-heap queue: request and response
// items, the error codes and the command that steps the row of key cells.
// ----------------------------------------------------------------------------
package tmhq_pkg;

	localparam int unsigned KEY_W = 32;
	localparam int unsigned OCC_W = 7;

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [OCC_W-1:0] occ_t;

	typedef enum logic [0:0] {
		ACT_INSERT = 1'b0,
		ACT_DELETE = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_EMPTY = 2'd1,
		ERR_FULL  = 2'd2
	} error_t;

	typedef struct packed {
		action_t action;
		key_t    value;
	} req_t;

	typedef struct packed {
		key_t   min_value;
		error_t error;
		occ_t   occupancy;
	} rsp_t;

	// Command broadcast to every cell of the row
	typedef struct packed {
		logic ins;
		logic del;
		key_t value;
	} cell_cmd_t;

endpackage

// ===== sv/tmhq_cell.sv =====
// ----------------------------------------------------------------------------
// tmhq_cell
// One slot of the sorted key row. On insert it compares the new key with its
// own and either keeps, takes the new key or takes its left neighbor's key.
// On delete it takes its right neighbor's key.
// ----------------------------------------------------------------------------
module tmhq_cell (
	input  logic                clk,
	input  tmhq_pkg::cell_cmd_t cmd,
	input  logic                occupied,
	input  logic                prev_gt,
	input  tmhq_pkg::key_t      prev_key,
	input  tmhq_pkg::key_t      next_key,
	output tmhq_pkg::key_t      key,
	output logic                gt
);
	import tmhq_pkg::*;

	key_t key_q;

	// Mark the cell as lying behind the new key; an empty slot counts as +inf
	assign gt  = !occupied || (cmd.value < key_q);
	assign key = key_q;

	// Shift right on insert, shift left on delete, hold otherwise
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (gt) begin
				key_q <= prev_gt ? prev_key : cmd.value;
			end
		end else if (cmd.del) begin
			key_q <= next_key;
		end
	end

endmodule

// ===== sv/ternary_min_heap_queue.sv =====
// ----------------------------------------------------------------------------
// ternary_min_heap_queue
// Min priority queue of signed 32-bit keys. Keys sit in a row of cells kept
// in ascending order; insert opens a gap at the first larger key, delete-min
// pops the head and shifts the row left.
//
//   port group  | dir | payload      | transfer when
//   ------------+-----+--------------+-------------------------
//   req         | in  | tmhq_pkg::req_t | req_valid & req_ready
//   rsp         | out | tmhq_pkg::rsp_t | rsp_valid & rsp_ready
//
// The whole cell row compares and shifts in the accept cycle, and the
// result is shown from the output register in the next cycle.
// One item per cycle is sustained while the response side keeps taking.
// A stalled response holds and blocks the next request until it is taken.
// Reset empties the queue at once; key cells hold no reset value.
// ----------------------------------------------------------------------------
module ternary_min_heap_queue #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  tmhq_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output tmhq_pkg::rsp_t rsp
);
	import tmhq_pkg::*;

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	typedef logic [CNT_W-1:0] cnt_t;

	cnt_t      count_q;
	cnt_t      count_nxt;
	logic      rsp_valid_q;
	rsp_t      rsp_q;
	logic      accept;
	logic      is_full;
	logic      is_empty;
	logic      do_ins;
	logic      do_del;
	error_t    err;
	cell_cmd_t cmd;

	key_t key [CAPACITY];
	logic [CAPACITY-1:0] gt;
	logic [CAPACITY-1:0] occupied;

	// Accept when the output register is free or being drained
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;

	assign is_full  = (count_q == cnt_t'(CAPACITY));
	assign is_empty = (count_q == '0);
	assign do_ins   = accept && (req.action == ACT_INSERT) && !is_full;
	assign do_del   = accept && (req.action == ACT_DELETE) && !is_empty;

	// Classify the request
	always_comb begin
		err = ERR_NONE;
		if (req.action == ACT_INSERT) begin
			if (is_full) begin
				err = ERR_FULL;
			end
		end else begin
			if (is_empty) begin
				err = ERR_EMPTY;
			end
		end
	end

	// Next element count
	always_comb begin
		count_nxt = count_q;
		if (do_ins) begin
			count_nxt = count_q + cnt_t'(1);
		end else if (do_del) begin
			count_nxt = count_q - cnt_t'(1);
		end
	end

	// Broadcast command: insert, delete and the new key
	assign cmd = {do_ins, do_del, req.value};

	// Row of key cells, head at index zero
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		key_t prev_key;
		key_t next_key;
		logic prev_gt;

		assign occupied[i] = (count_q > cnt_t'(i));

		if (i == 0) begin : g_head
			assign prev_key = '0;
			assign prev_gt  = 1'b0;
		end else begin : g_body
			assign prev_key = key[i-1];
			assign prev_gt  = gt[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_key = '0;
		end else begin : g_mid
			assign next_key = key[i+1];
		end

		tmhq_cell u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.occupied (occupied[i]),
			.prev_gt  (prev_gt),
			.prev_key (prev_key),
			.next_key (next_key),
			.key      (key[i]),
			.gt       (gt[i])
		);
	end

	// Element count and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Capture the response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.min_value <= do_del ? key[0] : '0;
			rsp_q.error     <= err;
			rsp_q.occupancy <= occ_t'(count_nxt);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	// Count never passes the number of cells
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(CAPACITY))
		else $error("element count beyond capacity");

	// Head of the row is never larger than the key behind it
	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= cnt_t'(2)) |-> !(key[1] < key[0]))
		else $error("key row out of order at head");

	// A full-insert error reports a full queue
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.error == ERR_FULL) |-> (rsp.occupancy == occ_t'(CAPACITY)))
		else $error("full error with wrong occupancy");

	// An empty-delete error returns zero and an empty queue
	a_empty_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.error == ERR_EMPTY) |-> (rsp.min_value == '0 && rsp.occupancy == '0))
		else $error("empty error with nonzero payload");

	// A successful delete pops the head key
	a_pop_head: assert property (@(posedge clk) disable iff (!arst_n)
		do_del |=> (rsp.min_value == $past(key[0])))
		else $error("delete did not return head key");
`endif

endmodule

// ===== bench/tb_ternary_min_heap_queue.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ternary_min_heap_queue
// Self-checking bench for the min priority queue. A ternary heap model in the
// scoreboard predicts every response from the accepted requests. Directed
// edge cases run first, then random phases that fill past capacity, drain
// past empty and mix both, with random idle cycles on both channels.
// ----------------------------------------------------------------------------

module tb_ternary_min_heap_queue;

	import tmhq_pkg::*;

	class heap_scoreboard #(int unsigned DEPTH = 64);

		key_t        heap_keys[DEPTH];
		int unsigned key_count;
		rsp_t        expected_q[$];
		int unsigned mismatches;
		int unsigned requests_seen;
		int unsigned responses_seen;
		int unsigned good_deletes;
		int unsigned empty_deletes;
		int unsigned full_inserts;
		int unsigned peak_count;

		function new();
			key_count      = 0;
			mismatches     = 0;
			requests_seen  = 0;
			responses_seen = 0;
			good_deletes   = 0;
			empty_deletes  = 0;
			full_inserts   = 0;
			peak_count     = 0;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function void swap_keys(int unsigned a, int unsigned b);
			key_t tmp;
			tmp          = heap_keys[a];
			heap_keys[a] = heap_keys[b];
			heap_keys[b] = tmp;
		endfunction

		// Move a new key toward the root while strictly smaller than its parent
		function void raise_key(int unsigned pos);
			int unsigned up;
			while (pos > 0) begin
				up = (pos - 1) / 3;
				if (!(heap_keys[pos] < heap_keys[up]))
					break;
				swap_keys(pos, up);
				pos = up;
			end
		endfunction

		// Push the root down toward the first strictly smallest child
		function void lower_root();
			int unsigned pos;
			int unsigned best;
			int unsigned child;
			pos = 0;
			while (pos < key_count) begin
				best = pos;
				for (int unsigned k = 1; k <= 3; k++) begin
					child = pos * 3 + k;
					if (child < key_count && heap_keys[child] < heap_keys[best])
						best = child;
				end
				if (best == pos)
					break;
				swap_keys(pos, best);
				pos = best;
			end
		endfunction

		// Apply one accepted request to the model and queue its response
		function void note_request(req_t r);
			rsp_t exp;
			exp.min_value = '0;
			exp.error     = ERR_NONE;
			requests_seen++;
			if (r.action == ACT_INSERT) begin
				if (key_count >= DEPTH) begin
					exp.error = ERR_FULL;
					full_inserts++;
				end else begin
					heap_keys[key_count] = r.value;
					key_count++;
					raise_key(key_count - 1);
				end
			end else begin
				if (key_count == 0) begin
					exp.error = ERR_EMPTY;
					empty_deletes++;
				end else begin
					exp.min_value = heap_keys[0];
					key_count--;
					good_deletes++;
					if (key_count > 0) begin
						heap_keys[0] = heap_keys[key_count];
						lower_root();
					end
				end
			end
			if (key_count > peak_count)
				peak_count = key_count;
			exp.occupancy = occ_t'(key_count);
			expected_q = {expected_q, exp};
		endfunction

		// Compare one accepted response against the oldest expectation
		function void check_response(rsp_t got);
			rsp_t exp;
			responses_seen++;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected response min_value %0d error %0d occupancy %0d",
					$time, got.min_value, got.error, got.occupancy);
				mismatches++;
				return;
			end
			exp = expected_q.pop_front();
			if (got.min_value !== exp.min_value) begin
				$display("%0t: min_value expected %0d actual %0d",
					$time, exp.min_value, got.min_value);
				mismatches++;
			end
			if (got.error !== exp.error) begin
				$display("%0t: error expected %0d actual %0d", $time, exp.error, got.error);
				mismatches++;
			end
			if (got.occupancy !== exp.occupancy) begin
				$display("%0t: occupancy expected %0d actual %0d",
					$time, exp.occupancy, got.occupancy);
				mismatches++;
			end
		endfunction

	endclass

	localparam int unsigned QUEUE_DEPTH = 64;
	localparam int unsigned ITEM_TARGET = 1150;
	localparam int unsigned LONG_HOLD   = 300;
	localparam int unsigned DRAIN_LIMIT = 5000;

	localparam key_t KEY_MIN = 32'sh8000_0000;
	localparam key_t KEY_MAX = 32'sh7FFF_FFFF;

	// Random phase kinds
	typedef enum int {
		PH_MIXED,
		PH_GROW,
		PH_SHRINK,
		PH_FILL_OVER,
		PH_DRAIN_UNDER
	} phase_kind_t;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	heap_scoreboard #(QUEUE_DEPTH) sb;

	bit          req_idle_on;
	bit          rsp_idle_on;
	int unsigned rsp_hold_cycles;
	int unsigned hold_runs;
	int unsigned phase_count;

	ternary_min_heap_queue #(
		.CAPACITY(QUEUE_DEPTH)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Offer one request and hold it until the transfer, then idle if drawn
	task automatic send_item(input action_t act, input key_t val);
		req_t        item;
		int unsigned gap;
		item.action = act;
		item.value  = val;
		req_valid <= 1'b1;
		req       <= item;
		do
			@(posedge clk);
		while (!req_ready);
		sb.note_request(item);
		gap = req_idle_on ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every response is back
	task automatic wait_all_returned();
		if (req_valid)
			req_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic key_t draw_key();
		case ($urandom_range(0, 9))
			5, 6, 7: draw_key = key_t'($signed($urandom_range(0, 15)) - 8);
			8: begin
				case ($urandom_range(0, 3))
					0: draw_key = KEY_MIN;
					1: draw_key = KEY_MAX;
					2: draw_key = '0;
					default: draw_key = '1;
				endcase
			end
			default: draw_key = key_t'($urandom);
		endcase
	endfunction

	// Response side: per-item stall, plus a long hold when requested
	initial begin
		int unsigned stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rsp_hold_cycles != 0) begin
				rsp_ready <= 1'b0;
				repeat (rsp_hold_cycles) @(posedge clk);
				rsp_hold_cycles = 0;
				hold_runs++;
			end
			stall = rsp_idle_on ? $urandom_range(0, 19) : 0;
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do
				@(posedge clk);
			while (!rsp_valid);
			sb.check_response(rsp);
		end
	end

	// Stimulus and end of run
	initial begin
		phase_kind_t kind;
		int unsigned phase_len;
		int unsigned ins_pct;
		int unsigned drain_wait;
		action_t     act;

		sb              = new();
		arst_n          = 1'b0;
		req_valid       = 1'b0;
		req             = '0;
		rsp_ready       = 1'b0;
		req_idle_on     = 1'b1;
		rsp_idle_on     = 1'b1;
		rsp_hold_cycles = 0;
		hold_runs       = 0;
		phase_count     = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty delete, extremes, equal keys, drain past empty
		send_item(ACT_DELETE, KEY_MAX);
		send_item(ACT_INSERT, '0);
		send_item(ACT_INSERT, KEY_MAX);
		send_item(ACT_INSERT, KEY_MIN);
		send_item(ACT_INSERT, '1);
		send_item(ACT_INSERT, 32'sd1);
		send_item(ACT_INSERT, 32'sd5);
		send_item(ACT_INSERT, 32'sd5);
		send_item(ACT_INSERT, 32'sd5);
		send_item(ACT_INSERT, KEY_MIN);
		repeat (9) send_item(ACT_DELETE, key_t'($urandom));
		send_item(ACT_DELETE, '1);
		send_item(ACT_INSERT, KEY_MAX);
		send_item(ACT_DELETE, '0);
		wait_all_returned();

		// Random phases until the item budget is spent
		while (sb.requests_seen < ITEM_TARGET) begin
			case (phase_count)
				0: kind = PH_MIXED;
				1: kind = PH_FILL_OVER;
				2: kind = PH_DRAIN_UNDER;
				default: kind = phase_kind_t'($urandom_range(0, 4));
			endcase
			// First phase runs back to back; later ones idle at random
			req_idle_on = (phase_count == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
			rsp_idle_on = (phase_count == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
			// Block the response side for a long stretch while requests keep coming
			if (phase_count == 3 || phase_count == 9)
				rsp_hold_cycles = LONG_HOLD;

			case (kind)
				PH_FILL_OVER: begin
					while (sb.key_count < QUEUE_DEPTH)
						send_item(ACT_INSERT, draw_key());
					repeat ($urandom_range(2, 5)) send_item(ACT_INSERT, draw_key());
				end
				PH_DRAIN_UNDER: begin
					while (sb.key_count > 0)
						send_item(ACT_DELETE, key_t'($urandom));
					repeat ($urandom_range(2, 5)) send_item(ACT_DELETE, key_t'($urandom));
				end
				default: begin
					if (kind == PH_GROW)
						ins_pct = 80;
					else if (kind == PH_SHRINK)
						ins_pct = 25;
					else
						ins_pct = 50;
					phase_len = $urandom_range(40, 140);
					repeat (phase_len) begin
						act = ($urandom_range(0, 99) < ins_pct) ? ACT_INSERT : ACT_DELETE;
						send_item(act, (act == ACT_INSERT) ? draw_key() : key_t'($urandom));
					end
				end
			endcase
			wait_all_returned();
			phase_count++;
		end

		// Let the last responses drain, bounded
		drain_wait = 0;
		while (sb.pending() != 0 && drain_wait < DRAIN_LIMIT) begin
			@(posedge clk);
			drain_wait++;
		end
		if (sb.pending() != 0) begin
			$display("%0t: %0d responses never arrived", $time, sb.pending());
			sb.mismatches += sb.pending();
		end
		repeat (10) @(posedge clk);

		$display("Ran %0d requests in %0d random phases; %0d good deletes, %0d empty deletes,",
			sb.requests_seen, phase_count, sb.good_deletes, sb.empty_deletes);
		$display("%0d inserts into a full queue, peak occupancy %0d, %0d long response holds.",
			sb.full_inserts, sb.peak_count, hold_runs);
		if (sb.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog
	initial begin
		#1_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/tmhq_pkg.sv
sv/tmhq_cell.sv
sv/ternary_min_heap_queue.sv
bench/tb_ternary_min_heap_queue.sv
